FILE: hw/rtl/vau_pkg.sv
// vau_pkg: shared types and constants of the 3d vector alu
// no dependencies
package vau_pkg;

  localparam int unsigned COMPONENT_BITS_DEF = 16;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_SUB  = 2'd1,
    CMD_DIST = 2'd2,
    CMD_NORM = 2'd3
  } cmd_e;

  typedef struct packed {
    logic en;
  } pipe_ctrl_t;

endpackage

FILE: hw/rtl/vau_front.sv
// vau_front: input register, add/sub and operand select, squares, sum of squares
// depends on vau_pkg
module vau_front #(
  parameter int unsigned W = vau_pkg::COMPONENT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  vau_pkg::pipe_ctrl_t     ctrl_i,
  input  logic                    valid_i,
  input  logic [1:0]              cmd_i,
  input  logic signed [W-1:0]     a_i [3],
  input  logic signed [W-1:0]     b_i [3],
  output logic                    valid_o,
  output logic [2*W+1:0]          rad_o,
  output logic [6*W+5:0]          side_o
);

  localparam int unsigned SW = 6 * W + 6;

  logic                v1_q, v2_q, v3_q, v4_q;
  logic [1:0]          cmd1_q;
  logic signed [W-1:0] a1_q [3];
  logic signed [W-1:0] b1_q [3];
  logic [W-1:0]        mag2_q [3];
  logic [SW-1:0]       side2_q, side3_q, side4_q;
  logic [2*W-1:0]      sq3_q [3];
  logic [2*W+1:0]      rad4_q;

  logic signed [W:0]   res2_d [3];
  logic [W-1:0]        mag2_d [3];
  logic                same2_d;

  always_comb begin
    logic signed [W:0] opd;
    same2_d = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (a1_q[i] != b1_q[i]) begin
        same2_d = 1'b0;
      end
      case (cmd1_q)
        vau_pkg::CMD_ADD: res2_d[i] = {a1_q[i][W-1], a1_q[i]} + {b1_q[i][W-1], b1_q[i]};
        vau_pkg::CMD_SUB: res2_d[i] = {a1_q[i][W-1], a1_q[i]} - {b1_q[i][W-1], b1_q[i]};
        default:          res2_d[i] = '0;
      endcase
      if (cmd1_q == vau_pkg::CMD_DIST) begin
        opd = {b1_q[i][W-1], b1_q[i]} - {a1_q[i][W-1], a1_q[i]};
      end else begin
        opd = {a1_q[i][W-1], a1_q[i]};
      end
      mag2_d[i] = opd[W] ? W'(-opd) : opd[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (ctrl_i.en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      cmd1_q  <= cmd_i;
      a1_q    <= a_i;
      b1_q    <= b_i;
      mag2_q  <= mag2_d;
      side2_q <= {a1_q[2], a1_q[1], a1_q[0], res2_d[2], res2_d[1], res2_d[0],
                  same2_d, cmd1_q};
      for (int i = 0; i < 3; i++) begin
        sq3_q[i] <= mag2_q[i] * mag2_q[i];
      end
      side3_q <= side2_q;
      rad4_q  <= (2*W+2)'(sq3_q[0]) + (2*W+2)'(sq3_q[1]) + (2*W+2)'(sq3_q[2]);
      side4_q <= side3_q;
    end
  end

  assign valid_o = v4_q;
  assign rad_o   = rad4_q;
  assign side_o  = side4_q;

endmodule

FILE: hw/rtl/vau_isqrt.sv
// vau_isqrt: pipelined integer square root, one root bit per stage
// depends on vau_pkg
module vau_isqrt #(
  parameter int unsigned RB = vau_pkg::COMPONENT_BITS_DEF + 1,
  parameter int unsigned SW = 6 * vau_pkg::COMPONENT_BITS_DEF + 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vau_pkg::pipe_ctrl_t ctrl_i,
  input  logic                valid_i,
  input  logic [2*RB-1:0]     rad_i,
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output logic [RB-1:0]       root_o,
  output logic [SW-1:0]       side_o
);

  localparam int unsigned RW = 2 * RB;

  logic            v_q    [RB];
  logic [RB-1:0]   root_q [RB];
  logic [SW-1:0]   side_q [RB];
  logic [RB+1:0]   rem_q  [RB-1];
  logic [RW-1:0]   rad_q  [RB-1];

  for (genvar k = 0; k < RB; k++) begin : g_stage
    logic          v_in;
    logic [RB-1:0] root_in;
    logic [SW-1:0] side_in;
    logic [RB+1:0] rem_in;
    logic [RW-1:0] rad_in;
    logic [RB+1:0] rem_sh, trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign root_in = '0;
      assign side_in = side_i;
      assign rem_in  = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    assign rem_sh = {rem_in[RB-1:0], rad_in[RW-1:RW-2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (ctrl_i.en) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        root_q[k] <= {root_in[RB-2:0], ge};
        side_q[k] <= side_in;
      end
    end

    if (k < RB - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (ctrl_i.en) begin
          rem_q[k] <= ge ? rem_sh - trial : rem_sh;
          rad_q[k] <= {rad_in[RW-3:0], 2'b00};
        end
      end
    end
  end

  assign valid_o = v_q[RB-1];
  assign root_o  = root_q[RB-1];
  assign side_o  = side_q[RB-1];

endmodule

FILE: hw/rtl/vau_out.sv
// vau_out: normalize and result select, output register with skid stage
// depends on vau_pkg
module vau_out #(
  parameter int unsigned W = vau_pkg::COMPONENT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  output vau_pkg::pipe_ctrl_t ctrl_o,
  input  logic                valid_i,
  input  logic [W:0]          root_i,
  input  logic [6*W+5:0]      side_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [4*W+4:0]      data_o
);

  localparam int unsigned OW = 4 * W + 5;

  logic [1:0]          cmd;
  logic                same;
  logic signed [W:0]   rs [3];
  logic signed [W-1:0] a  [3];
  logic signed [W:0]   fin [3];
  logic [W:0]          dist_val;
  logic [OW-1:0]       res_d;

  logic                out_v_q, spare_v_q;
  logic [OW-1:0]       out_q, spare_q;
  logic                take;

  assign cmd  = side_i[1:0];
  assign same = side_i[2];
  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign rs[i] = side_i[3+i*(W+1) +: W+1];
    assign a[i]  = side_i[3+3*(W+1)+i*W +: W];
  end

  always_comb begin
    logic [W:0] aabs;
    for (int i = 0; i < 3; i++) begin
      aabs = a[i][W-1] ? -{a[i][W-1], a[i]} : {1'b0, a[i]};
      if (cmd != vau_pkg::CMD_NORM) begin
        fin[i] = rs[i];
      end else if (root_i == '0) begin
        fin[i] = {a[i][W-1], a[i]};
      end else if (aabs >= root_i) begin
        fin[i] = a[i][W-1] ? '1 : (W+1)'(1);
      end else begin
        fin[i] = '0;
      end
    end
    dist_val = (cmd == vau_pkg::CMD_DIST) ? root_i : '0;
    res_d    = {same, dist_val, fin[2], fin[1], fin[0]};
  end

  assign ctrl_o.en = !spare_v_q;
  assign take      = valid_i && !spare_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      spare_v_q <= 1'b0;
    end else if (spare_v_q) begin
      if (ready_i) begin
        spare_v_q <= 1'b0;
      end
    end else if (!out_v_q || ready_i) begin
      out_v_q <= take;
    end else if (take) begin
      spare_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (spare_v_q) begin
      if (ready_i) begin
        out_q <= spare_q;
      end
    end else if (!out_v_q || ready_i) begin
      out_q <= res_d;
    end else if (take) begin
      spare_q <= res_d;
    end
  end

  assign valid_o = out_v_q;
  assign data_o  = out_q;

  a_spare_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spare_v_q |-> out_v_q) else $error("skid entry without output entry");
  a_spare_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spare_v_q && !ready_i |=> spare_v_q) else $error("skid entry lost");
  a_dist_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_q[4*W+3 -: W+1] != '0) |-> (out_q[3*W+2:0] == '0))
    else $error("distance with nonzero vector result");

endmodule

FILE: hw/rtl/vector3_integer_alu_unit.sv
// vector3_integer_alu_unit: top level of the integer 3d vector alu
// a request passes the front registers, the root stages and the output register before its result is valid
// throughput one request per cycle when not stalled, set by the one-bit-per-stage root pipeline
// the whole pipeline stalls only while the output skid entry is occupied
// reset is asynchronous active low and clears valid bits only
// depends on vau_pkg, vau_front, vau_isqrt, vau_out
module vector3_integer_alu_unit #(
  parameter int unsigned COMPONENT_BITS = vau_pkg::COMPONENT_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // command, a_x, a_y, a_z, b_x, b_y, b_z
  input  logic [((6*COMPONENT_BITS+2+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // res_x, res_y, res_z, dist_res, same
  output logic [((4*COMPONENT_BITS+5+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned W   = COMPONENT_BITS;
  localparam int unsigned SW  = 6 * W + 6;
  localparam int unsigned OW  = 4 * W + 5;
  localparam int unsigned OTW = ((OW + 7) / 8) * 8;

  vau_pkg::pipe_ctrl_t ctrl;
  logic signed [W-1:0] a [3];
  logic signed [W-1:0] b [3];
  logic                f_valid, r_valid;
  logic [2*W+1:0]      rad;
  logic [SW-1:0]       f_side, r_side;
  logic [W:0]          root;
  logic [OW-1:0]       odata;

  for (genvar i = 0; i < 3; i++) begin : g_in
    assign a[i] = s_axis_tdata[2+i*W +: W];
    assign b[i] = s_axis_tdata[2+(3+i)*W +: W];
  end

  assign s_axis_tready = ctrl.en;

  vau_front #(.W(W)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .valid_i (s_axis_tvalid),
    .cmd_i   (s_axis_tdata[1:0]),
    .a_i     (a),
    .b_i     (b),
    .valid_o (f_valid),
    .rad_o   (rad),
    .side_o  (f_side)
  );

  vau_isqrt #(.RB(W + 1), .SW(SW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .valid_i (f_valid),
    .rad_i   (rad),
    .side_i  (f_side),
    .valid_o (r_valid),
    .root_o  (root),
    .side_o  (r_side)
  );

  vau_out #(.W(W)) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_o  (ctrl),
    .valid_i (r_valid),
    .root_i  (root),
    .side_i  (r_side),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (odata)
  );

  assign m_axis_tdata = OTW'(odata);

endmodule
